/* src/lcsts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the LCS text similarity block.
// No dependencies; every other source file imports this package.
package lcsts_pkg;

   localparam int MAX_LEN_DEFAULT = 256;
   localparam int CHAR_W          = 16;
   localparam int OUT_LEN_W       = 9;
   localparam int SIM_W           = 17;
   localparam int DIV_CNT_W       = $clog2(SIM_W + 1);

   localparam logic [SIM_W-1:0] SIM_ONE      = 17'h10000;
   localparam logic [SIM_W-1:0] SIM_ZERO     = 17'h00000;
   localparam logic [SIM_W-1:0] THRESH_RESET = 17'd55705;

   localparam logic MODE_FIRST  = 1'b0;
   localparam logic MODE_SECOND = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [CHAR_W-1:0] char_code;
      logic              empty_string;
      logic              last_char;
   } lcsts_req_type;

   typedef struct packed {
      logic [OUT_LEN_W-1:0] common_length;
      logic [OUT_LEN_W-1:0] longer_length;
      logic [SIM_W-1:0]     similarity;
      logic                 is_similar;
      logic                 overflow;
   } lcsts_rsp_type;

   typedef enum logic [0:0] {
      PH_FIRST,
      PH_SECOND
   } lcsts_phase_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CHECK,
      ST_LCS,
      ST_DIV
   } lcsts_state_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_FETCH,
      ENG_SWEEP,
      ENG_FLUSH
   } lcsts_eng_state_type;

endpackage

/* src/lcsts_text_ram.sv */
`timescale 1ns / 1ps
// Single-port-write, single-port-read text memory, one code unit per entry.
// Depends on lcsts_pkg for the code unit width.
module lcsts_text_ram
   import lcsts_pkg::*;
#(
   parameter int DEPTH = MAX_LEN_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [CHAR_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [CHAR_W-1:0]        rd_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lcsts_lcs_engine.sv */
`timescale 1ns / 1ps
// LCS table walk over a single row memory: one cell per cycle, a fetch per row.
// Depends on lcsts_pkg; reads both text memories through their read ports.
module lcsts_lcs_engine
   import lcsts_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [$clog2(MAX_LEN+1)-1:0]       first_len,
   input  logic [$clog2(MAX_LEN+1)-1:0]       second_len,
   output logic                               a_rd_en,
   output logic [$clog2(MAX_LEN)-1:0]         a_rd_addr,
   input  logic [CHAR_W-1:0]                  a_rd_data,
   output logic                               b_rd_en,
   output logic [$clog2(MAX_LEN)-1:0]         b_rd_addr,
   input  logic [CHAR_W-1:0]                  b_rd_data,
   output logic                               done,
   output logic [$clog2(MAX_LEN+1)-1:0]       common
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);

   lcsts_eng_state_type state_ff, state_in;

   logic [LEN_W-1:0]  i_ff, i_in;
   logic [LEN_W-1:0]  j_ff, j_in;
   logic              p_valid_ff, p_valid_in;
   logic [ADDR_W-1:0] p_addr_ff, p_addr_in;
   logic              p_first_ff, p_first_in;
   logic              p_top_ff, p_top_in;
   logic              p_last_ff, p_last_in;
   logic [LEN_W-1:0]  diag_ff, left_ff;
   logic [LEN_W-1:0]  common_ff;
   logic              done_ff, done_in;

   logic [LEN_W-1:0]  row_mem [MAX_LEN];
   logic [LEN_W-1:0]  row_q_ff;
   logic              row_rd_en;

   logic [LEN_W-1:0]  n_last, m_last;
   logic [LEN_W-1:0]  diag, left, up, cur;

   assign n_last = first_len - LEN_W'(1);
   assign m_last = second_len - LEN_W'(1);

   // Row and column edges of the table read as zero.
   assign diag = p_first_ff ? '0 : diag_ff;
   assign left = p_first_ff ? '0 : left_ff;
   assign up   = p_top_ff   ? '0 : row_q_ff;
   assign cur  = (a_rd_data == b_rd_data) ? diag + LEN_W'(1)
               : ((up > left) ? up : left);

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      p_valid_in = 1'b0;
      p_addr_in  = j_ff[ADDR_W-1:0];
      p_first_in = (j_ff == '0);
      p_top_in   = (i_ff == '0);
      p_last_in  = (i_ff == n_last) && (j_ff == m_last);
      done_in    = 1'b0;
      a_rd_en    = 1'b0;
      row_rd_en  = 1'b0;
      b_rd_en    = 1'b0;
      case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               i_in     = '0;
               state_in = ENG_FETCH;
            end
         end
         ENG_FETCH: begin
            a_rd_en  = 1'b1;
            j_in     = '0;
            state_in = ENG_SWEEP;
         end
         ENG_SWEEP: begin
            b_rd_en    = 1'b1;
            row_rd_en  = 1'b1;
            p_valid_in = 1'b1;
            if (j_ff == m_last) begin
               if (i_ff == n_last) begin
                  state_in = ENG_FLUSH;
               end else begin
                  i_in     = i_ff + LEN_W'(1);
                  state_in = ENG_FETCH;
               end
            end else begin
               j_in = j_ff + LEN_W'(1);
            end
         end
         ENG_FLUSH: begin
            done_in  = 1'b1;
            state_in = ENG_IDLE;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   assign a_rd_addr = i_ff[ADDR_W-1:0];
   assign b_rd_addr = j_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ENG_IDLE;
         p_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_valid_ff <= p_valid_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      p_addr_ff  <= p_addr_in;
      p_first_ff <= p_first_in;
      p_top_ff   <= p_top_in;
      p_last_ff  <= p_last_in;
      if (p_valid_ff) begin
         diag_ff <= up;
         left_ff <= cur;
         if (p_last_ff) begin
            common_ff <= cur;
         end
      end
   end

   // Write back the cell; the next read in the same row is one column ahead.
   always_ff @(posedge clock) begin
      if (p_valid_ff) begin
         row_mem[p_addr_ff] <= cur;
      end
      if (row_rd_en) begin
         row_q_ff <= row_mem[j_ff[ADDR_W-1:0]];
      end
   end

   assign done   = done_ff;
   assign common = common_ff;

endmodule

/* src/lcsts_divider.sv */
`timescale 1ns / 1ps
// Restoring divider: floor(dividend * 2^16 / divisor), one quotient bit a cycle.
// Depends on lcsts_pkg; expects dividend <= divisor and divisor > 0.
module lcsts_divider
   import lcsts_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [$clog2(MAX_LEN+1)-1:0] dividend,
   input  logic [$clog2(MAX_LEN+1)-1:0] divisor,
   output logic                         done,
   output logic [SIM_W-1:0]             quotient
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [LEN_W:0]       rem_ff;
   logic [LEN_W-1:0]     dsor_ff;
   logic [SIM_W-1:0]     quo_ff;

   logic                 ge;
   logic [LEN_W:0]       diff;

   assign ge   = rem_ff >= {1'b0, dsor_ff};
   assign diff = ge ? rem_ff - {1'b0, dsor_ff} : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == DIV_CNT_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, dividend};
         dsor_ff <= divisor;
         quo_ff  <= '0;
         cnt_ff  <= DIV_CNT_W'(SIM_W);
      end else if (busy_ff) begin
         // Remainder stays below the divisor, so doubling fits one extra bit.
         rem_ff <= {diff[LEN_W-1:0], 1'b0};
         quo_ff <= {quo_ff[SIM_W-2:0], ge};
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/lcs_text_similarity.sv */
`timescale 1ns / 1ps
//  channel   ports                              direction  handshake
//  request   start, busy, req_item              in         start && !busy
//  response  rsp_valid, rsp_item                out        rsp_valid, one cycle
//  config    csr_wr_en, csr_wr_data             in         csr_wr_en
//
// Code units load one per cycle while not busy. The item that ends the second
// string raises busy. With both strings non-empty, the table walk then takes
// one cell per cycle through the single row memory port, passing a fetch
// state before each row, and the divider follows; else the check state emits.
// Reset is synchronous and clears control state; text memories are not cleared.
// The receiver cannot stall: each result shows for one cycle on rsp_valid.
module lcs_text_similarity
   import lcsts_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lcsts_req_type    req_item,
   output logic             rsp_valid,
   output lcsts_rsp_type    rsp_item,
   input  logic             csr_wr_en,
   input  logic [SIM_W-1:0] csr_wr_data
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);

   lcsts_state_type state_ff, state_in;
   lcsts_phase_type phase_ff, phase_in;
   logic [LEN_W-1:0] first_len_ff, first_len_in;
   logic [LEN_W-1:0] second_len_ff, second_len_in;
   logic             cut_ff, cut_in;
   logic [SIM_W-1:0] thresh_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lcsts_rsp_type    rsp_item_ff, rsp_item_in;

   logic [LEN_W-1:0]  first_base;
   logic [LEN_W-1:0]  longer;
   logic              a_wr_en, b_wr_en;
   logic              a_rd_en, b_rd_en;
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   logic [CHAR_W-1:0] a_rd_data, b_rd_data;
   logic              eng_start, eng_done;
   logic [LEN_W-1:0]  eng_common;
   logic              div_start, div_done;
   logic [SIM_W-1:0]  div_quotient;
   logic              emit;
   logic [LEN_W-1:0]  emit_common;
   logic [SIM_W-1:0]  emit_sim;

   // A first-string item after the first string ended restarts the load.
   assign first_base = (phase_ff == PH_SECOND) ? '0 : first_len_ff;
   assign longer     = (first_len_ff > second_len_ff) ? first_len_ff : second_len_ff;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      cut_in        = cut_ff;
      a_wr_en       = 1'b0;
      b_wr_en       = 1'b0;
      eng_start     = 1'b0;
      div_start     = 1'b0;
      emit          = 1'b0;
      emit_common   = '0;
      emit_sim      = SIM_ZERO;
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               if (req_item.mode == MODE_FIRST) begin
                  if (phase_ff == PH_SECOND) begin
                     second_len_in = '0;
                     cut_in        = 1'b0;
                  end
                  first_len_in = first_base;
                  if (req_item.empty_string) begin
                     first_len_in = '0;
                  end else if (first_base < LEN_W'(MAX_LEN)) begin
                     a_wr_en      = 1'b1;
                     first_len_in = first_base + LEN_W'(1);
                  end else begin
                     cut_in = 1'b1;
                  end
                  phase_in = (req_item.empty_string || req_item.last_char) ?
                             PH_SECOND : PH_FIRST;
               end else if (phase_ff == PH_SECOND) begin
                  if (req_item.empty_string) begin
                     second_len_in = '0;
                  end else if (second_len_ff < LEN_W'(MAX_LEN)) begin
                     b_wr_en       = 1'b1;
                     second_len_in = second_len_ff + LEN_W'(1);
                  end else begin
                     cut_in = 1'b1;
                  end
                  if (req_item.empty_string || req_item.last_char) begin
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            if ((first_len_ff == '0) && (second_len_ff == '0)) begin
               emit     = 1'b1;
               emit_sim = SIM_ONE;
            end else if ((first_len_ff == '0) || (second_len_ff == '0)) begin
               emit = 1'b1;
            end else begin
               eng_start = 1'b1;
               state_in  = ST_LCS;
            end
         end
         ST_LCS: begin
            if (eng_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               emit        = 1'b1;
               emit_common = eng_common;
               emit_sim    = div_quotient;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      rsp_valid_in = emit;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_item_in.common_length = OUT_LEN_W'(emit_common);
         rsp_item_in.longer_length = OUT_LEN_W'(longer);
         rsp_item_in.similarity    = emit_sim;
         rsp_item_in.is_similar    = emit_sim > thresh_ff;
         rsp_item_in.overflow      = cut_ff;
         // Drop the load state for the next pair of strings.
         state_in      = ST_LOAD;
         phase_in      = PH_FIRST;
         first_len_in  = '0;
         second_len_in = '0;
         cut_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         phase_ff      <= PH_FIRST;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         cut_ff        <= 1'b0;
         thresh_ff     <= THRESH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         cut_ff        <= cut_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   lcsts_text_ram #(
      .DEPTH (MAX_LEN)
   ) u_first_text (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (first_base[ADDR_W-1:0]),
      .wr_data (req_item.char_code),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   lcsts_text_ram #(
      .DEPTH (MAX_LEN)
   ) u_second_text (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (second_len_ff[ADDR_W-1:0]),
      .wr_data (req_item.char_code),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   lcsts_lcs_engine #(
      .MAX_LEN (MAX_LEN)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (eng_start),
      .first_len  (first_len_ff),
      .second_len (second_len_ff),
      .a_rd_en    (a_rd_en),
      .a_rd_addr  (a_rd_addr),
      .a_rd_data  (a_rd_data),
      .b_rd_en    (b_rd_en),
      .b_rd_addr  (b_rd_addr),
      .b_rd_data  (b_rd_data),
      .done       (eng_done),
      .common     (eng_common)
   );

   lcsts_divider #(
      .MAX_LEN (MAX_LEN)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (eng_common),
      .divisor  (longer),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy      = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   a_busy_fall_emits: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("compute ended without a response");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (first_len_ff <= LEN_W'(MAX_LEN)) && (second_len_ff <= LEN_W'(MAX_LEN)))
      else $error("string length beyond maximum");

   a_sim_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.similarity <= SIM_ONE))
      else $error("similarity above one");

endmodule
